### src/ttag_pkg.sv
package ttag_pkg;

  // Number of tensor dimensions handled by the address generator.
  localparam int unsigned NDIM = 4;

  // Configuration port layout.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM0   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM1   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM2   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM3   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PERMUTATION = 3'd4;

  // Permutation register: two bits per output dimension.
  localparam int unsigned         PERM_W        = 8;
  localparam int unsigned         PERM_SEL_W    = 2;
  localparam logic [PERM_W-1:0]   PERM_IDENTITY = 8'd228;

  // Destination index bits that leave the block; higher bits read as zero.
  localparam int unsigned DEST_KEEP_W = 32;

  // Per-stage control that travels with each transaction.
  typedef struct packed {
    logic valid;
    logic last;
  } ttag_ctl_t;

endpackage

### src/ttag_coord_counter.sv
module ttag_coord_counter
  import ttag_pkg::*;
#(
  parameter int unsigned DIM_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  logic                             advance_i,
  input  logic [NDIM-1:0][DIM_WIDTH-1:0]   ext_i,
  output logic [NDIM-1:0][DIM_WIDTH-1:0]   coord_o,
  output logic                             last_o
);

  logic [NDIM-1:0][DIM_WIDTH-1:0] coord_q, coord_d;
  logic [NDIM-1:0]                wrap;
  logic [NDIM-1:0]                inc;

  // Row-major carry chain, innermost dimension first.
  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      wrap[d] = ((DIM_WIDTH+1)'(coord_q[d]) + (DIM_WIDTH+1)'(1)) >= (DIM_WIDTH+1)'(ext_i[d]);
    end
    inc[NDIM-1] = 1'b1;
    for (int d = NDIM - 2; d >= 0; d--) begin
      inc[d] = inc[d+1] & wrap[d+1];
    end
    for (int d = 0; d < NDIM; d++) begin
      if (!inc[d]) begin
        coord_d[d] = coord_q[d];
      end else if (wrap[d]) begin
        coord_d[d] = '0;
      end else begin
        coord_d[d] = coord_q[d] + DIM_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
    end else if (clear_i) begin
      coord_q <= '0;
    end else if (advance_i) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;
  assign last_o  = &wrap;

endmodule

### src/ttag_horner_cell.sv
module ttag_horner_cell
  import ttag_pkg::*;
#(
  parameter int unsigned STAGE      = 1,
  parameter int unsigned DIM_WIDTH  = 16,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ttag_ctl_t                           ctl_i,
  output logic                                ready_o,
  input  logic [STAGE*DIM_WIDTH-1:0]          acc_i,
  input  logic [NDIM-1:0][DIM_WIDTH-1:0]      coords_i,
  input  logic [DIM_WIDTH-1:0]                ext_i,
  input  logic [DATA_WIDTH-1:0]               value_i,
  output ttag_ctl_t                           ctl_o,
  input  logic                                ready_i,
  output logic [(STAGE+1)*DIM_WIDTH-1:0]      acc_o,
  output logic [NDIM-1:0][DIM_WIDTH-1:0]      coords_o,
  output logic [DATA_WIDTH-1:0]               value_o
);

  localparam int unsigned OUT_W = (STAGE + 1) * DIM_WIDTH;

  ttag_ctl_t                      ctl_q;
  logic [OUT_W-1:0]               acc_q, acc_d;
  logic [NDIM-1:0][DIM_WIDTH-1:0] coords_q;
  logic [DATA_WIDTH-1:0]          value_q;

  assign ready_o = !ctl_q.valid || ready_i;

  // One Horner step: acc * extent + coordinate of this output dimension.
  assign acc_d = (OUT_W'(acc_i) * OUT_W'(ext_i)) + OUT_W'(coords_i[STAGE]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      acc_q    <= acc_d;
      coords_q <= coords_i;
      value_q  <= value_i;
    end
  end

  assign ctl_o    = ctl_q;
  assign acc_o    = acc_q;
  assign coords_o = coords_q;
  assign value_o  = value_q;

endmodule

### src/tensor_transpose_address_gen_core.sv
// Pipeline: capture stage, then three Horner cells; the last is the output register.
// Throughput: one element per cycle while the result side is not stalled; the 48x16
// multiply in the last cell sets the clock.
// Reset: sizes read 1, permutation is identity, coordinates are zero, pipeline empty.
// Any configuration write returns the coordinate counter to the first element.
module tensor_transpose_address_gen_core
  import ttag_pkg::*;
#(
  parameter int unsigned MAX_RANK    = 4,
  parameter int unsigned DIM_WIDTH   = 16,
  parameter int unsigned INDEX_WIDTH = 32,
  parameter int unsigned DATA_WIDTH  = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // element input channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [DATA_WIDTH-1:0]   element_value_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [INDEX_WIDTH-1:0]  dest_index_o,
  output logic [DATA_WIDTH-1:0]   value_out_o,
  output logic                    last_element_o,
  output logic                    index_overflow_o
);

  localparam int unsigned EXACT_W = NDIM * DIM_WIDTH;

  // ---------------------------------------------------------------------------
  // Configuration registers. Write them only while the pipeline is empty (the block
  // does not enforce it); then extents stay stable for every transaction in flight.
  // ---------------------------------------------------------------------------
  logic [NDIM-1:0][DIM_WIDTH-1:0] size_q;
  logic [PERM_W-1:0]              perm_q;
  logic                           cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NDIM; d++) begin
        size_q[d] <= DIM_WIDTH'(1);
      end
      perm_q <= PERM_IDENTITY;
    end else if (cfg_fire) begin
      unique case (cfg_index_i) inside
        REG_SIZE_DIM0, REG_SIZE_DIM1, REG_SIZE_DIM2, REG_SIZE_DIM3: begin
          size_q[cfg_index_i[PERM_SEL_W-1:0]] <= cfg_data_i[DIM_WIDTH-1:0];
        end
        REG_PERMUTATION: begin
          perm_q <= cfg_data_i[PERM_W-1:0];
        end
        default: begin
          // index beyond the register list: counter clear only
        end
      endcase
    end
  end

  // Effective extents: zero acts as one, and leading dims above the rank are one.
  logic [NDIM-1:0][DIM_WIDTH-1:0] ext;

  for (genvar d = 0; d < NDIM; d++) begin : g_ext
    if (d < NDIM - MAX_RANK) begin : g_unused
      assign ext[d] = DIM_WIDTH'(1);
    end else begin : g_used
      assign ext[d] = (size_q[d] == '0) ? DIM_WIDTH'(1) : size_q[d];
    end
  end

  // ---------------------------------------------------------------------------
  // Input coordinate counter and its permuted view.
  // ---------------------------------------------------------------------------
  logic [NDIM-1:0][DIM_WIDTH-1:0] coord;
  logic [NDIM-1:0][DIM_WIDTH-1:0] pcoord;
  logic [NDIM-1:0][DIM_WIDTH-1:0] pext;
  logic                           coord_last;
  logic                           in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  ttag_coord_counter #(
    .DIM_WIDTH (DIM_WIDTH)
  ) u_counter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_fire),
    .advance_i (in_fire),
    .ext_i     (ext),
    .coord_o   (coord),
    .last_o    (coord_last)
  );

  // Output dim k takes input dim perm[k]. Coordinates always stay below their
  // extent, so no clamp is needed here.
  always_comb begin
    for (int k = 0; k < NDIM; k++) begin
      pcoord[k] = coord[perm_q[PERM_SEL_W*k +: PERM_SEL_W]];
      pext[k]   = ext[perm_q[PERM_SEL_W*k +: PERM_SEL_W]];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: capture the transaction with its permuted coordinates. Its
  // accumulator is simply the outermost output coordinate.
  // ---------------------------------------------------------------------------
  ttag_ctl_t                                  ctl_s    [NDIM];
  logic      [NDIM-1:0]                       ready_s;
  logic      [NDIM-1:0][EXACT_W-1:0]          acc_s;
  logic      [NDIM-1:0][DIM_WIDTH-1:0]        coords_s [NDIM];
  logic      [DATA_WIDTH-1:0]                 value_s  [NDIM];

  assign ready_s[0] = !ctl_s[0].valid || ready_s[1];
  assign in_ready_o = ready_s[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s[0] <= '0;
    end else if (ready_s[0]) begin
      ctl_s[0].valid <= in_valid_i;
      ctl_s[0].last  <= coord_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      coords_s[0] <= pcoord;
      value_s[0]  <= element_value_i;
    end
  end

  assign acc_s[0] = EXACT_W'(coords_s[0][0]);

  // ---------------------------------------------------------------------------
  // Horner chain: cell k folds in output dimension k.
  // ---------------------------------------------------------------------------
  for (genvar k = 1; k < NDIM; k++) begin : g_cell
    logic next_ready;

    if (k == NDIM - 1) begin : g_tail
      assign next_ready = out_ready_i;
    end else begin : g_mid
      assign next_ready = ready_s[k+1];
      assign acc_s[k][EXACT_W-1:(k+1)*DIM_WIDTH] = '0;
    end

    ttag_horner_cell #(
      .STAGE      (k),
      .DIM_WIDTH  (DIM_WIDTH),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl_s[k-1]),
      .ready_o  (ready_s[k]),
      .acc_i    (acc_s[k-1][k*DIM_WIDTH-1:0]),
      .coords_i (coords_s[k-1]),
      .ext_i    (pext[k]),
      .value_i  (value_s[k-1]),
      .ctl_o    (ctl_s[k]),
      .ready_i  (next_ready),
      .acc_o    (acc_s[k][(k+1)*DIM_WIDTH-1:0]),
      .coords_o (coords_s[k]),
      .value_o  (value_s[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Result: the last cell's register drives the outputs directly.
  // ---------------------------------------------------------------------------
  logic [EXACT_W-1:0] exact;

  assign exact          = acc_s[NDIM-1];
  assign out_valid_o    = ctl_s[NDIM-1].valid;
  assign last_element_o = ctl_s[NDIM-1].last;
  assign value_out_o    = value_s[NDIM-1];

  // Index is taken modulo 2^INDEX_WIDTH and only the low DEST_KEEP_W bits leave.
  for (genvar b = 0; b < INDEX_WIDTH; b++) begin : g_dest
    if (b < EXACT_W && b < DEST_KEEP_W) begin : g_bit
      assign dest_index_o[b] = exact[b];
    end else begin : g_zero
      assign dest_index_o[b] = 1'b0;
    end
  end

  if (INDEX_WIDTH >= EXACT_W) begin : g_no_ovf
    assign index_overflow_o = 1'b0;
  end else begin : g_ovf
    assign index_overflow_o = |exact[EXACT_W-1:INDEX_WIDTH];
  end

endmodule

### tb/tb_tensor_transpose_address_gen_core.sv
module tb_tensor_transpose_address_gen_core;
  import ttag_pkg::*;

  // Block configuration mirrored here; the DUT is built with the same values.
  localparam int unsigned RANK    = 4;
  localparam int unsigned DIM_W   = 16;
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned DATA_W  = 64;

  localparam int unsigned ITEMS        = 900;        // random elements, roughly
  localparam int unsigned DRAIN_CYCLES = 12;         // 4-stage pipe plus margin
  localparam int unsigned TIMEOUT      = 3_000_000;  // hard stop, in time units

  // Spare register slots above the permutation register: a write there only
  // rewinds the coordinate counter.
  localparam logic [CFG_INDEX_W-1:0] REG_LAST = CFG_INDEX_W'((1 << CFG_INDEX_W) - 1);

  localparam logic [CFG_DATA_W-1:0] SIZE_ZERO = '0;
  localparam logic [CFG_DATA_W-1:0] SIZE_MAX  = '1;

  // Permutation codes, two bits per output dim, output dim 0 in bits 1:0.
  localparam logic [PERM_W-1:0] PERM_REVERSE   = 8'd27;   // 3,2,1,0
  localparam logic [PERM_W-1:0] PERM_ROTATE    = 8'd147;  // 3,0,1,2: innermost goes outer
  localparam logic [PERM_W-1:0] PERM_ALL_OUTER = 8'd0;    // every output dim reads dim 0
  localparam logic [PERM_W-1:0] PERM_ALL_INNER = 8'd255;  // every output dim reads dim 3

  typedef struct packed {
    logic [DEST_KEEP_W-1:0] dest;
    logic [DATA_W-1:0]      value;
    logic                   last;
    logic                   ovf;
  } placement_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_ELEM, ROW_ELEM_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_INDEX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0]   data;
    placement_t              want;   // want.value doubles as the element sent
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [DATA_W-1:0]      element_value_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [INDEX_W-1:0]     dest_index_o;
  logic [DATA_W-1:0]      value_out_o;
  logic                   last_element_o;
  logic                   index_overflow_o;

  // Shadow of the block: register file and input-coordinate counter.
  logic [DIM_W-1:0]  dim_size [NDIM];
  logic [PERM_W-1:0] perm_code;
  logic [DIM_W-1:0]  in_coord [NDIM];

  placement_t  placement_q [$];   // destinations still owed by the block
  dir_row_t    dir_rows [$];
  int unsigned elems_sent;
  int unsigned mismatches;
  logic        sender_idle;
  logic        sink_idle;

  tensor_transpose_address_gen_core #(
    .MAX_RANK   (RANK),
    .DIM_WIDTH  (DIM_W),
    .INDEX_WIDTH(INDEX_W),
    .DATA_WIDTH (DATA_W)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dest_index_o    (dest_index_o),
    .value_out_o     (value_out_o),
    .last_element_o  (last_element_o),
    .index_overflow_o(index_overflow_o)
  );

  always #10 clk_i = ~clk_i;

  // Effective extent: a zero size counts as one, and leading dims beyond
  // the rank are pinned to one.
  function automatic logic [DIM_W:0] eff_extent(input logic [1:0] d);
    if (int'(d) < int'(NDIM) - int'(RANK)) return 1;
    return (dim_size[d] == '0) ? 1 : {1'b0, dim_size[d]};
  endfunction

  // Destination of the element at the current input coordinate, then step
  // the row-major counter (innermost dim first, wrapping after the last).
  function automatic placement_t place_element(input logic [DATA_W-1:0] value);
    placement_t       p;
    logic [63:0]      exact;
    logic [1:0]       src;
    logic [DIM_W:0]   ext;
    logic [DIM_W:0]   c;
    logic             stepped;
    exact = '0;
    p.last = 1'b1;
    // Horner over the permuted shape; output dim 0 is the outermost.
    for (int k = 0; k < NDIM; k++) begin
      src = perm_code[PERM_SEL_W*k +: PERM_SEL_W];
      ext = eff_extent(src);
      c = {1'b0, in_coord[src]};
      if (c >= ext) c = ext - 1;
      exact = exact * ext + c;
    end
    for (int k = 0; k < NDIM; k++)
      if ({1'b0, in_coord[k]} + 1 < eff_extent(2'(k))) p.last = 1'b0;
    p.dest  = exact[DEST_KEEP_W-1:0];
    p.ovf   = |exact[63:INDEX_W];
    p.value = value;
    stepped = 1'b0;
    for (int d = NDIM - 1; d >= 0; d--) begin
      if (!stepped) begin
        if ({1'b0, in_coord[d]} + 1 < eff_extent(2'(d))) begin
          in_coord[d] = in_coord[d] + 1'b1;
          stepped = 1'b1;
        end else begin
          in_coord[d] = '0;
        end
      end
    end
    return p;
  endfunction

  // Register write; held valid is left up so back-to-back writes need no
  // drop in between. The element sender lowers it.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SIZE_DIM0, REG_SIZE_DIM1, REG_SIZE_DIM2, REG_SIZE_DIM3: begin
        dim_size[idx[1:0]] = data[DIM_W-1:0];
      end
      REG_PERMUTATION: begin
        perm_code = data[PERM_W-1:0];
      end
      default: begin
      end
    endcase
    // every write, mapped or not, rewinds the counter
    in_coord = '{default: '0};
  endtask

  // One element transaction, with an optional random gap in front of it.
  // A typed row overrides the predicted index fields with hand values.
  task automatic send_element(input logic [DATA_W-1:0] value, input logic typed,
                              input placement_t typed_p);
    placement_t p;
    cfg_valid_i <= 1'b0;
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    p = place_element(value);
    if (typed) begin
      p.dest = typed_p.dest;
      p.last = typed_p.last;
      p.ovf  = typed_p.ovf;
    end
    placement_q.push_back(p);
    elems_sent++;
  endtask

  // Stop sending and wait until every owed result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic dir_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic dir_row_t elem_row(input logic [DATA_W-1:0] value);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ELEM;
    r.want.value = value;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic [DATA_W-1:0] value,
                                         input logic [DEST_KEEP_W-1:0] dest,
                                         input logic last, input logic ovf);
    dir_row_t r;
    r.kind = ROW_ELEM_TYPED;
    r.idx  = '0;
    r.data = '0;
    r.want = '{dest: dest, value: value, last: last, ovf: ovf};
    return r;
  endfunction

  // Result side: random stall bursts while sink_idle is set, always ready
  // otherwise.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (sink_idle && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // Scoreboard: each result transaction against the oldest owed placement.
  always @(posedge clk_i) begin
    placement_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (placement_q.size() == 0) begin
        $error("unexpected result: dest_index %0h value_out %0h", dest_index_o, value_out_o);
        mismatches++;
      end else begin
        want = placement_q.pop_front();
        if (dest_index_o !== want.dest) begin
          $error("dest_index: expected %0h, got %0h", want.dest, dest_index_o);
          mismatches++;
        end
        if (value_out_o !== want.value) begin
          $error("value_out: expected %0h, got %0h", want.value, value_out_o);
          mismatches++;
        end
        if (last_element_o !== want.last) begin
          $error("last_element: expected %0b, got %0b", want.last, last_element_o);
          mismatches++;
        end
        if (index_overflow_o !== want.ovf) begin
          $error("index_overflow: expected %0b, got %0b", want.ovf, index_overflow_o);
          mismatches++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0]     v;
    logic [CFG_DATA_W-1:0] data;
    logic [63:0]           vol;
    int unsigned           n;
    int unsigned           pick;

    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    element_value_i <= '0;
    dim_size    = '{default: DIM_W'(1)};
    perm_code   = PERM_IDENTITY;
    in_coord    = '{default: '0};
    elems_sent  = 0;
    mismatches  = 0;
    sender_idle = 1'b1;
    sink_idle   = 1'b1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Index fields are typed in where they are obvious:
    // unit tensor after reset, small identity walk, and the overflow corner.
    // Reset shape is a single element: every element is first and last.
    dir_rows.push_back(typed_row(64'h0, 32'd0, 1'b1, 1'b0));
    dir_rows.push_back(typed_row('1, 32'd0, 1'b1, 1'b0));
    // zero size behaves as extent one
    dir_rows.push_back(cfg_row(REG_SIZE_DIM3, SIZE_ZERO));
    dir_rows.push_back(typed_row(64'hA5A5_5A5A_0F0F_F0F0, 32'd0, 1'b1, 1'b0));
    // shape 1x1x2x3, identity: destination equals input order, then wrap
    dir_rows.push_back(cfg_row(REG_SIZE_DIM3, 16'd3));
    dir_rows.push_back(cfg_row(REG_SIZE_DIM2, 16'd2));
    dir_rows.push_back(typed_row(64'h1111, 32'd0, 1'b0, 1'b0));
    dir_rows.push_back(typed_row(64'h2222, 32'd1, 1'b0, 1'b0));
    dir_rows.push_back(elem_row(64'h3333));
    dir_rows.push_back(elem_row(64'h4444));
    dir_rows.push_back(elem_row(64'h5555));
    dir_rows.push_back(typed_row(64'h6666, 32'd5, 1'b1, 1'b0));
    dir_rows.push_back(typed_row(64'h7777, 32'd0, 1'b0, 1'b0));
    // full reversal, then a non-bijective map where all outputs read dim 0
    dir_rows.push_back(cfg_row(REG_PERMUTATION, 16'(PERM_REVERSE)));
    dir_rows.push_back(elem_row(64'h8000_0000_0000_0001));
    dir_rows.push_back(elem_row(64'h0123_4567_89AB_CDEF));
    dir_rows.push_back(elem_row(64'hFEDC_BA98_7654_3210));
    dir_rows.push_back(cfg_row(REG_PERMUTATION, 16'(PERM_ALL_OUTER)));
    dir_rows.push_back(elem_row(64'h5A5A_5A5A_5A5A_5A5A));
    dir_rows.push_back(elem_row(64'hA5A5_A5A5_A5A5_A5A5));
    // all sizes at max, innermost dim moved outermost: the second element
    // lands at 65535^3 = 0xFFFD_0002_FFFF, past 32 bits
    dir_rows.push_back(cfg_row(REG_SIZE_DIM0, SIZE_MAX));
    dir_rows.push_back(cfg_row(REG_SIZE_DIM1, SIZE_MAX));
    dir_rows.push_back(cfg_row(REG_SIZE_DIM2, SIZE_MAX));
    dir_rows.push_back(cfg_row(REG_SIZE_DIM3, SIZE_MAX));
    dir_rows.push_back(cfg_row(REG_PERMUTATION, 16'(PERM_ROTATE)));
    dir_rows.push_back(typed_row(64'hDEAD_BEEF_0000_0001, 32'd0, 1'b0, 1'b0));
    dir_rows.push_back(typed_row(64'hDEAD_BEEF_0000_0002, 32'h0002_FFFF, 1'b0, 1'b1));
    // unmapped register slot: counter rewinds, registers stay
    dir_rows.push_back(cfg_row(REG_LAST, 16'hFFFF));
    dir_rows.push_back(typed_row(64'hDEAD_BEEF_0000_0003, 32'd0, 1'b0, 1'b0));
    dir_rows.push_back(typed_row(64'hDEAD_BEEF_0000_0004, 32'h0002_FFFF, 1'b0, 1'b1));
    dir_rows.push_back(cfg_row(REG_PERMUTATION, 16'(PERM_ALL_INNER)));
    dir_rows.push_back(elem_row(64'h0));
    dir_rows.push_back(elem_row('1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_element(dir_rows[i].want.value, dir_rows[i].kind == ROW_ELEM_TYPED,
                     dir_rows[i].want);
      end
    end

    // Random phases. Each starts from an idle block, rewrites a random subset
    // of the registers, then mostly streams whole tensors (small shapes so
    // the last flag and the wrap come up often), sometimes a partial one.
    while (elems_sent < ITEMS) begin
      drain();
      // final stretch runs with no idling on either side
      sender_idle = (elems_sent < ITEMS - 150) && ($urandom_range(0, 3) != 0);
      sink_idle   = (elems_sent < ITEMS - 150) && ($urandom_range(0, 3) != 0);
      for (int r = 0; r <= int'(REG_PERMUTATION); r++) begin
        if ($urandom_range(0, 9) < 7) begin
          if (r == int'(REG_PERMUTATION)) begin
            data = 16'($urandom);
          end else begin
            pick = $urandom_range(0, 19);
            if (pick == 0)      data = SIZE_ZERO;
            else if (pick == 1) data = SIZE_MAX;
            else if (pick == 2) data = 16'($urandom);
            else                data = 16'($urandom_range(1, 4));
          end
          write_reg(CFG_INDEX_W'(r), data);
        end
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(int'(REG_PERMUTATION) + 1, int'(REG_LAST))),
                  16'($urandom));

      vol = 1;
      for (int d = 0; d < NDIM; d++) vol = vol * eff_extent(2'(d));
      if (vol <= 48) begin
        n = int'(vol) * $urandom_range(1, 3);
        // a broken tail now and then: the next phase picks up mid-tensor
        if ($urandom_range(0, 4) == 0) n += $urandom_range(1, 3);
      end else begin
        n = $urandom_range(8, 40);
      end

      for (int j = 0; j < n; j++) begin
        v = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 1) ? '1 : '0;
        send_element(v, 1'b0, '0);
      end
    end

    drain();
    cfg_valid_i <= 1'b0;
    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && placement_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
src/ttag_pkg.sv
src/ttag_coord_counter.sv
src/ttag_horner_cell.sv
src/tensor_transpose_address_gen_core.sv
tb/tb_tensor_transpose_address_gen_core.sv
